FILE: hw/rtl/flr_pkg.sv
`timescale 1ns / 1ps

package flr_pkg;

    // One input beat: a single character of literal text.
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_flr_in;

    // One result beat: the verdict after the character.
    typedef struct packed {
        logic accepted;
        logic rejected;
        logic token_end;
    } t_flr_out;

    // Automaton states. Codes 13 to 15 are never entered.
    typedef enum logic [3:0] {
        ST_START        = 4'd0,
        ST_POINT        = 4'd1,
        ST_INT          = 4'd2,
        ST_DEAD         = 4'd3,
        ST_FRAC         = 4'd4,
        ST_INT_US       = 4'd5,
        ST_FRAC_US      = 4'd6,
        ST_INT_PT       = 4'd7,
        ST_EXP          = 4'd8,
        ST_SUFFIX       = 4'd9,
        ST_EXP_SIGN     = 4'd10,
        ST_EXP_DIG      = 4'd11,
        ST_EXP_US       = 4'd12
    } t_flr_state;

    // Character codes that the grammar looks for.
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_POINT      = 8'h2E;
    localparam logic [7:0] CH_EXP_LO     = 8'h65;
    localparam logic [7:0] CH_EXP_UP     = 8'h45;
    localparam logic [7:0] CH_SUF_LO     = 8'h66;
    localparam logic [7:0] CH_SUF_UP     = 8'h46;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI   = 8'h39;

endpackage

FILE: hw/rtl/float_literal_recognizer_core.sv
`timescale 1ns / 1ps

// Path: a beat is taken into the input register and its verdict is then
// registered in the result register, once that register is free.
// Throughput: one character per cycle while the output is not stalled; the state
// register feedback through the next-state logic is the loop that sets that rate.
// Reset (synchronous, active low) returns the automaton to its start state
// and empties the input and result registers.
module float_literal_recognizer_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  flr_pkg::t_flr_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output flr_pkg::t_flr_out o_out
);
    import flr_pkg::*;

    logic       r_in_valid;
    t_flr_in    r_in;
    logic       r_out_valid;
    t_flr_out   r_out;
    t_flr_state r_state;
    t_flr_state n_state;
    t_flr_state n_dfa;
    t_flr_out   n_out;
    logic       advance;
    logic       is_digit;
    logic       is_us;
    logic       is_pt;
    logic       is_exp;
    logic       is_suf;
    logic       is_sign;

    // The held character moves on when the result register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // Character classes of the held beat.
    always_comb begin
        is_digit = (r_in.char_code >= CH_DIGIT_LO) && (r_in.char_code <= CH_DIGIT_HI);
        is_us    = (r_in.char_code == CH_UNDERSCORE);
        is_pt    = (r_in.char_code == CH_POINT);
        is_exp   = (r_in.char_code == CH_EXP_LO) || (r_in.char_code == CH_EXP_UP);
        is_suf   = (r_in.char_code == CH_SUF_LO) || (r_in.char_code == CH_SUF_UP);
        is_sign  = (r_in.char_code == CH_PLUS) || (r_in.char_code == CH_MINUS);
    end

    // Next state of the automaton; anything not listed falls to the dead state.
    always_comb begin
        n_dfa = ST_DEAD;
        unique case (r_state)
            ST_START: begin
                if (is_pt)         n_dfa = ST_POINT;
                else if (is_digit) n_dfa = ST_INT;
            end
            ST_POINT: begin
                if (is_digit) n_dfa = ST_FRAC;
            end
            ST_INT: begin
                if (is_digit)    n_dfa = ST_INT;
                else if (is_pt)  n_dfa = ST_INT_PT;
                else if (is_us)  n_dfa = ST_INT_US;
                else if (is_exp) n_dfa = ST_EXP;
                else if (is_suf) n_dfa = ST_SUFFIX;
            end
            ST_FRAC: begin
                if (is_digit)    n_dfa = ST_FRAC;
                else if (is_us)  n_dfa = ST_FRAC_US;
                else if (is_exp) n_dfa = ST_EXP;
                else if (is_suf) n_dfa = ST_SUFFIX;
            end
            ST_INT_US: begin
                if (is_us)         n_dfa = ST_INT_US;
                else if (is_digit) n_dfa = ST_INT;
            end
            ST_FRAC_US: begin
                if (is_us)         n_dfa = ST_FRAC_US;
                else if (is_digit) n_dfa = ST_FRAC;
            end
            ST_INT_PT: begin
                if (is_digit)    n_dfa = ST_FRAC;
                else if (is_suf) n_dfa = ST_SUFFIX;
                else if (is_exp) n_dfa = ST_EXP;
            end
            ST_EXP: begin
                if (is_digit)     n_dfa = ST_EXP_DIG;
                else if (is_sign) n_dfa = ST_EXP_SIGN;
            end
            ST_EXP_SIGN: begin
                if (is_digit) n_dfa = ST_EXP_DIG;
            end
            ST_EXP_DIG: begin
                if (is_digit)    n_dfa = ST_EXP_DIG;
                else if (is_us)  n_dfa = ST_EXP_US;
                else if (is_suf) n_dfa = ST_SUFFIX;
            end
            ST_EXP_US: begin
                if (is_digit)   n_dfa = ST_EXP_DIG;
                else if (is_us) n_dfa = ST_EXP_US;
            end
            default: begin
                n_dfa = ST_DEAD;
            end
        endcase
        // The last character of a token sends the automaton back to start.
        n_state = r_in.is_last ? ST_START : n_dfa;
    end

    // Verdict taken from the state after the current character.
    always_comb begin
        n_out.accepted  = (n_dfa == ST_FRAC) || (n_dfa == ST_INT_PT) ||
                          (n_dfa == ST_SUFFIX) || (n_dfa == ST_EXP_DIG);
        n_out.rejected  = (n_dfa == ST_DEAD);
        n_out.token_end = r_in.is_last;
    end

    // Control registers: stage valids and automaton state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_START;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A beat marked last leaves the automaton in its start state.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.is_last |=> r_state == ST_START)
        else $error("automaton did not restart after the last character");

    // Within a token, the rejected flag matches the state the automaton moved to.
    a_reject_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.is_last |=> o_out.rejected == (r_state == ST_DEAD))
        else $error("rejected flag disagrees with automaton state");

    // Within a token, the accepted flag matches the state the automaton moved to.
    a_accept_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.is_last |=> o_out.accepted == ((r_state == ST_FRAC) ||
            (r_state == ST_INT_PT) || (r_state == ST_SUFFIX) || (r_state == ST_EXP_DIG)))
        else $error("accepted flag disagrees with automaton state");

    // A result waiting on a stall is not overwritten by the next character.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !advance)
        else $error("result register overwritten while stalled");

endmodule
